### src/assert_macros.svh
// Concurrent assertion helpers, synchronous active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

### src/mhpq_pkg.sv
`timescale 1ns / 1ps
package mhpq_pkg;

    localparam int DATA_W       = 32;
    localparam int OCC_W        = 6;
    localparam int CAPACITY_DEF = 32;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic                     mode;
        logic signed [DATA_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] removed_value;
        t_status                  status;
        logic [OCC_W-1:0]         occupancy;
    } t_out;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_seq_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_RM_ROOT,
        S_RM_LAST,
        S_DN_CHK,
        S_DN_L,
        S_DN_R,
        S_DN_MOVE,
        S_DONE
    } t_state;

endpackage

### src/max_heap_priority_queue.sv
`timescale 1ns / 1ps
// Channel   Valid / ready               Payload      Direction
// input     i_in_valid / o_in_ready     i_in_data    mode, value
// output    o_out_valid / i_out_ready   o_out_data   removed_value, status, occupancy
//
// One item at a time: not ready again until the last item is through the sequencer.
// Insert: sifts up past each smaller parent, at most log2(CAPACITY) of them.
// Remove: takes the root and sifts the last item down from it, unless now empty.
// Refused items go straight to the result. RAM reads are registered.
// Synchronous active-low reset empties the queue; no RAM clearing pass is needed.
// A new transaction is accepted while the previous result waits in the output register.
`include "assert_macros.svh"
module max_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mhpq_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output mhpq_pkg::t_out o_out_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int DW = mhpq_pkg::DATA_W;

    mhpq_pkg::t_seq_status w_seq;
    mhpq_pkg::t_out        w_res;
    logic                  w_res_ready;
    logic                  w_start;
    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [DW-1:0]         w_wr_data;
    logic                  w_rd_en;
    logic [AW-1:0]         w_rd_addr;
    logic [DW-1:0]         w_rd_data;

    logic                  r_out_valid;
    mhpq_pkg::t_out        r_out;

    assign o_in_ready  = w_seq.idle;
    assign w_start     = i_in_valid && w_seq.idle;
    assign w_res_ready = !r_out_valid || i_out_ready;

    mhpq_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_item     (i_in_data),
        .i_res_ready(w_res_ready),
        .o_status   (w_seq),
        .o_res      (w_res),
        .o_wr_en    (w_wr_en),
        .o_wr_addr  (w_wr_addr),
        .o_wr_data  (w_wr_data),
        .o_rd_en    (w_rd_en),
        .o_rd_addr  (w_rd_addr),
        .i_rd_data  (w_rd_data)
    );

    mhpq_ram #(
        .WIDTH(DW),
        .DEPTH(CAPACITY)
    ) u_heap_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_seq.res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_seq.res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `ASSERT_NOW(a_full_occupancy, i_clk, i_rst_n,
        o_out_valid && (o_out_data.status == mhpq_pkg::ST_FULL),
        (o_out_data.occupancy == mhpq_pkg::OCC_W'(CAPACITY)) && (o_out_data.removed_value == '0))
    `ASSERT_NOW(a_empty_result, i_clk, i_rst_n,
        o_out_valid && (o_out_data.status == mhpq_pkg::ST_EMPTY),
        (o_out_data.occupancy == '0) && (o_out_data.removed_value == '0))

endmodule

### src/mhpq_ram.sv
`timescale 1ns / 1ps
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/mhpq_ctrl.sv
`timescale 1ns / 1ps
module mhpq_ctrl #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  mhpq_pkg::t_in                      i_item,
    input  logic                               i_res_ready,
    output mhpq_pkg::t_seq_status              o_status,
    output mhpq_pkg::t_out                     o_res,
    output logic                               o_wr_en,
    output logic [$clog2(CAPACITY)-1:0]        o_wr_addr,
    output logic [mhpq_pkg::DATA_W-1:0]        o_wr_data,
    output logic                               o_rd_en,
    output logic [$clog2(CAPACITY)-1:0]        o_rd_addr,
    input  logic [mhpq_pkg::DATA_W-1:0]        i_rd_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;
    localparam int DW = mhpq_pkg::DATA_W;

    mhpq_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_pos, n_pos;
    logic [DW-1:0]     r_val, n_val;
    logic [DW-1:0]     r_best_val, n_best_val;
    logic              r_best_sel, n_best_sel;
    logic [AW-1:0]     r_best_idx, n_best_idx;
    logic [DW-1:0]     r_removed, n_removed;
    mhpq_pkg::t_status r_status, n_status;

    logic [AW-1:0]     w_parent;
    logic [IW-1:0]     w_left;
    logic [IW-1:0]     w_right;
    logic [IW-1:0]     w_count_ext;
    logic signed [DW-1:0] w_cmp_a;
    logic signed [DW-1:0] w_cmp_b;
    logic              w_gt;

    assign w_parent    = (r_pos - AW'(1)) >> 1;
    assign w_left      = IW'({r_pos, 1'b1});
    assign w_right     = w_left + IW'(1);
    assign w_count_ext = IW'(r_count);

    // shared signed compare unit
    always_comb begin
        case (r_state)
            mhpq_pkg::S_UP_CMP: begin
                w_cmp_a = r_val;
                w_cmp_b = i_rd_data;
            end
            mhpq_pkg::S_DN_L: begin
                w_cmp_a = i_rd_data;
                w_cmp_b = r_val;
            end
            mhpq_pkg::S_DN_R: begin
                w_cmp_a = i_rd_data;
                w_cmp_b = r_best_val;
            end
            default: begin
                w_cmp_a = r_val;
                w_cmp_b = r_best_val;
            end
        endcase
    end

    assign w_gt = w_cmp_a > w_cmp_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mhpq_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_val      <= n_val;
        r_best_val <= n_best_val;
        r_best_sel <= n_best_sel;
        r_best_idx <= n_best_idx;
        r_removed  <= n_removed;
        r_status   <= n_status;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pos      = r_pos;
        n_val      = r_val;
        n_best_val = r_best_val;
        n_best_sel = r_best_sel;
        n_best_idx = r_best_idx;
        n_removed  = r_removed;
        n_status   = r_status;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_pos;
        o_wr_data  = r_val;
        o_rd_en    = 1'b0;
        o_rd_addr  = '0;

        case (r_state)
            mhpq_pkg::S_IDLE: begin
                if (i_start) begin
                    n_removed = '0;
                    n_status  = mhpq_pkg::ST_DONE;
                    if (i_item.mode == mhpq_pkg::MODE_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = mhpq_pkg::ST_FULL;
                            n_state  = mhpq_pkg::S_DONE;
                        end else begin
                            n_pos   = AW'(r_count);
                            n_val   = i_item.value;
                            n_count = r_count + CW'(1);
                            n_state = mhpq_pkg::S_UP_CHK;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = mhpq_pkg::ST_EMPTY;
                            n_state  = mhpq_pkg::S_DONE;
                        end else begin
                            o_rd_en   = 1'b1;
                            o_rd_addr = '0;
                            n_state   = mhpq_pkg::S_RM_ROOT;
                        end
                    end
                end
            end
            mhpq_pkg::S_UP_CHK: begin
                if (r_pos == '0) begin
                    o_wr_en = 1'b1;
                    n_state = mhpq_pkg::S_DONE;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = w_parent;
                    n_state   = mhpq_pkg::S_UP_CMP;
                end
            end
            mhpq_pkg::S_UP_CMP: begin
                o_wr_en = 1'b1;
                if (w_gt) begin
                    o_wr_data = i_rd_data;
                    n_pos     = w_parent;
                    n_state   = mhpq_pkg::S_UP_CHK;
                end else begin
                    n_state = mhpq_pkg::S_DONE;
                end
            end
            mhpq_pkg::S_RM_ROOT: begin
                n_removed = i_rd_data;
                o_rd_en   = 1'b1;
                o_rd_addr = AW'(r_count - CW'(1));
                n_count   = r_count - CW'(1);
                n_state   = mhpq_pkg::S_RM_LAST;
            end
            mhpq_pkg::S_RM_LAST: begin
                n_val = i_rd_data;
                n_pos = '0;
                if (r_count == '0) begin
                    n_state = mhpq_pkg::S_DONE;
                end else begin
                    n_state = mhpq_pkg::S_DN_CHK;
                end
            end
            mhpq_pkg::S_DN_CHK: begin
                if (w_left >= w_count_ext) begin
                    o_wr_en = 1'b1;
                    n_state = mhpq_pkg::S_DONE;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = AW'(w_left);
                    n_state   = mhpq_pkg::S_DN_L;
                end
            end
            mhpq_pkg::S_DN_L: begin
                if (w_gt) begin
                    n_best_val = i_rd_data;
                    n_best_sel = 1'b1;
                    n_best_idx = AW'(w_left);
                end else begin
                    n_best_val = r_val;
                    n_best_sel = 1'b0;
                end
                if (w_right < w_count_ext) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = AW'(w_right);
                    n_state   = mhpq_pkg::S_DN_R;
                end else begin
                    n_state = mhpq_pkg::S_DN_MOVE;
                end
            end
            mhpq_pkg::S_DN_R: begin
                if (w_gt) begin
                    n_best_val = i_rd_data;
                    n_best_sel = 1'b1;
                    n_best_idx = AW'(w_right);
                end
                n_state = mhpq_pkg::S_DN_MOVE;
            end
            mhpq_pkg::S_DN_MOVE: begin
                o_wr_en = 1'b1;
                if (r_best_sel) begin
                    o_wr_data = r_best_val;
                    n_pos     = r_best_idx;
                    n_state   = mhpq_pkg::S_DN_CHK;
                end else begin
                    n_state = mhpq_pkg::S_DONE;
                end
            end
            mhpq_pkg::S_DONE: begin
                if (i_res_ready) begin
                    n_state = mhpq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mhpq_pkg::S_IDLE;
            end
        endcase
    end

    assign o_status.idle      = (r_state == mhpq_pkg::S_IDLE);
    assign o_status.res_valid = (r_state == mhpq_pkg::S_DONE);

    assign o_res.removed_value = r_removed;
    assign o_res.status        = r_status;
    assign o_res.occupancy     = mhpq_pkg::OCC_W'(r_count);

endmodule
